### rtl/core/i2cms_pkg.sv
// Shared types and codes for the I2C master byte sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

    localparam int BUFFER_DEPTH_DEF = 16;

    // field widths
    localparam int MODE_W   = 3;
    localparam int ADDR_W   = 7;
    localparam int COUNT_W  = 5;
    localparam int BIDX_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 3;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    // command modes
    localparam logic [MODE_W-1:0] MODE_START_RD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START_WR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD_TX  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EVENT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_RX  = 3'd4;

    // bus actions
    localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SEND  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DUMMY = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TAKEN = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd5;

    typedef enum logic [4:0] {
        PH_ERROR    = 5'b00001,
        PH_READY    = 5'b00010,
        PH_HEADER   = 5'b00100,
        PH_TRANSFER = 5'b01000,
        PH_SENT     = 5'b10000
    } phase_t;

    // where the outgoing bus byte comes from
    typedef enum logic [1:0] {
        BSEL_ZERO = 2'd0,
        BSEL_ADDR = 2'd1,
        BSEL_TX   = 2'd2
    } byte_sel_t;

    // control word carried from the state stage to the output register
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        byte_sel_t           byte_sel;
        logic [BYTE_W-1:0]   addr_byte;
        logic                no_ack_next;
        logic                busy;
        logic                no_response;
        logic                error;
        logic                rx_sel;
    } stage_ctl_t;

endpackage

### rtl/core/i2c_master_byte_sequencer.sv
// Top level: I2C master byte-level transaction sequencer.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: mode, tdata: command/event fields
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser: bus_action, tdata: byte/status
//
// One word in, one word out. Accept updates the sequencer state, loads stage 1 and
// reads the buffer memories; the output register loads from stage 1 when free. One
// word per cycle sustained while the output is not stalled; the state update is the
// loop. Reset (aresetn low, synchronous) returns the sequencer to ready; buffers are
// not cleared. A stalled output holds both stages; a full stage 1 drops s_axis_tready.
`timescale 1ns / 1ps

module i2c_master_byte_sequencer
    import i2cms_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [6:0] slave_address, [11:7] byte_count, [15:12] buffer_index, [23:16] tx_byte,
    // [24] ack_missing, [25] arbitration_lost, [33:26] bus_data, [39:34] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [2:0] mode
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] bus_byte, [8] no_ack_next, [9] busy_res, [10] no_response, [11] error,
    // [19:12] read_data, [23:20] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] bus_action
    output logic [M_TUSER_W-1:0] m_axis_tuser
);

    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    // input fields
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  slave_address;
    logic [COUNT_W-1:0] byte_count;
    logic [BIDX_W-1:0]  buffer_index;
    logic [BYTE_W-1:0]  tx_byte;
    logic               ack_missing;
    logic               arbitration_lost;
    logic [BYTE_W-1:0]  bus_data;

    assign mode             = s_axis_tuser[2:0];
    assign slave_address    = s_axis_tdata[6:0];
    assign byte_count       = s_axis_tdata[11:7];
    assign buffer_index     = s_axis_tdata[15:12];
    assign tx_byte          = s_axis_tdata[23:16];
    assign ack_missing      = s_axis_tdata[24];
    assign arbitration_lost = s_axis_tdata[25];
    assign bus_data         = s_axis_tdata[33:26];

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] byte_index_reg, byte_index_next;
    logic [COUNT_W-1:0] length_reg, length_next;
    logic               dir_write_reg, dir_write_next;
    logic               resp_missing_reg, resp_missing_next;

    // buffers
    logic [BYTE_W-1:0] tx_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rx_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] tx_rdata_reg;
    logic [BYTE_W-1:0] rx_rdata_reg;

    // pipeline
    stage_ctl_t        ctl_reg, ctl_next;
    logic              p1_valid_reg;
    logic              m_valid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic               s_fire;
    logic               out_ready;
    logic               tx_we, rx_we;
    logic [COUNT_W-1:0] idx_inc;
    logic               idx_in_range;
    logic               bidx_in_range;
    logic [COUNT_W-1:0] count_clamped;
    logic [IDX_W-1:0]   seq_addr;
    logic [IDX_W-1:0]   buf_addr;
    logic [BYTE_W-1:0]  bus_byte_sel;

    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !p1_valid_reg || out_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign idx_inc       = byte_index_reg + COUNT_W'(1);
    assign idx_in_range  = 32'(byte_index_reg) < 32'(BUFFER_DEPTH);
    assign bidx_in_range = 32'(buffer_index) < 32'(BUFFER_DEPTH);
    assign seq_addr      = IDX_W'(byte_index_reg);
    assign buf_addr      = IDX_W'(buffer_index);

    always_comb begin
        if (byte_count == '0) begin
            count_clamped = COUNT_W'(1);
        end else if (32'(byte_count) > 32'(BUFFER_DEPTH)) begin
            count_clamped = COUNT_W'(BUFFER_DEPTH);
        end else begin
            count_clamped = byte_count;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        length_next       = length_reg;
        dir_write_next    = dir_write_reg;
        resp_missing_next = resp_missing_reg;
        tx_we             = 1'b0;
        rx_we             = 1'b0;
        ctl_next          = '0;
        ctl_next.action   = ACT_NONE;
        ctl_next.byte_sel = BSEL_ZERO;
        ctl_next.addr_byte = {slave_address, ~(mode == MODE_START_WR)};

        case (mode)
            MODE_START_RD, MODE_START_WR: begin
                length_next       = count_clamped;
                byte_index_next   = '0;
                dir_write_next    = (mode == MODE_START_WR);
                resp_missing_next = 1'b1;
                phase_next        = PH_HEADER;
                ctl_next.action   = ACT_START;
                ctl_next.byte_sel = BSEL_ADDR;
            end
            MODE_LOAD_TX: begin
                tx_we = bidx_in_range;
            end
            MODE_EVENT: begin
                if (phase_reg inside {PH_HEADER, PH_TRANSFER, PH_SENT}) begin
                    if (arbitration_lost) begin
                        phase_next      = PH_ERROR;
                        ctl_next.action = ACT_STOP;
                    end else if (phase_reg == PH_HEADER && ack_missing) begin
                        phase_next      = PH_READY;
                        ctl_next.action = ACT_STOP;
                    end else if (phase_reg == PH_HEADER && !dir_write_reg) begin
                        phase_next           = PH_TRANSFER;
                        ctl_next.action      = ACT_DUMMY;
                        ctl_next.no_ack_next = (length_reg == COUNT_W'(1));
                    end else if (phase_reg == PH_SENT) begin
                        phase_next        = PH_READY;
                        resp_missing_next = 1'b0;
                        ctl_next.action   = ACT_STOP;
                    end else if (dir_write_reg) begin
                        // send next buffered byte (header ack or transfer phase)
                        ctl_next.action   = ACT_SEND;
                        ctl_next.byte_sel = idx_in_range ? BSEL_TX : BSEL_ZERO;
                        byte_index_next   = idx_inc;
                        phase_next        = (idx_inc >= length_reg) ? PH_SENT : PH_TRANSFER;
                    end else begin
                        // read transfer: store received byte
                        rx_we           = idx_in_range;
                        byte_index_next = idx_inc;
                        if (idx_inc >= length_reg) begin
                            phase_next        = PH_READY;
                            resp_missing_next = 1'b0;
                            ctl_next.action   = ACT_STOP;
                        end else begin
                            ctl_next.action      = ACT_TAKEN;
                            ctl_next.no_ack_next =
                                ({1'b0, idx_inc} + (COUNT_W+1)'(1)) == {1'b0, length_reg};
                        end
                    end
                end
            end
            MODE_READ_RX: begin
                ctl_next.rx_sel = bidx_in_range;
            end
            default: begin
            end
        endcase

        ctl_next.busy        = phase_next inside {PH_HEADER, PH_TRANSFER, PH_SENT};
        ctl_next.no_response = resp_missing_next;
        ctl_next.error       = (phase_next == PH_ERROR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_READY;
            byte_index_reg   <= '0;
            length_reg       <= COUNT_W'(1);
            dir_write_reg    <= 1'b0;
            resp_missing_reg <= 1'b1;
        end else if (s_fire) begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            length_reg       <= length_next;
            dir_write_reg    <= dir_write_next;
            resp_missing_reg <= resp_missing_next;
        end
    end

    // buffer memories, registered reads
    always_ff @(posedge aclk) begin
        if (s_fire && tx_we) begin
            tx_mem[buf_addr] <= tx_byte;
        end
        if (s_fire) begin
            tx_rdata_reg <= tx_mem[seq_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && rx_we) begin
            rx_mem[seq_addr] <= bus_data;
        end
        if (s_fire) begin
            rx_rdata_reg <= rx_mem[buf_addr];
        end
    end

    // stage 1: control word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            p1_valid_reg <= 1'b1;
        end else if (out_ready) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ctl_reg <= ctl_next;
        end
    end

    always_comb begin
        case (ctl_reg.byte_sel)
            BSEL_ADDR: bus_byte_sel = ctl_reg.addr_byte;
            BSEL_TX:   bus_byte_sel = tx_rdata_reg;
            default:   bus_byte_sel = '0;
        endcase
    end

    // stage 2: output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && p1_valid_reg) begin
            m_tuser_reg <= ctl_reg.action;
            m_tdata_reg <= {4'b0,
                            ctl_reg.rx_sel ? rx_rdata_reg : BYTE_W'(0),
                            ctl_reg.error,
                            ctl_reg.no_response,
                            ctl_reg.busy,
                            ctl_reg.no_ack_next,
                            bus_byte_sel};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // checks
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == ACT_START |-> m_axis_tdata[9])
        else $error("start word without busy");

    a_err_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[11] && m_axis_tdata[9]))
        else $error("error and busy together");

    a_nak_action: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[8] |->
            (m_axis_tuser == ACT_DUMMY || m_axis_tuser == ACT_TAKEN))
        else $error("no-ack request on wrong action");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !out_ready |=> p1_valid_reg && $stable(ctl_reg))
        else $error("stage 1 word lost under stall");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TRANSFER |-> byte_index_reg < length_reg)
        else $error("byte index past transfer length");

endmodule
